>>> hdl/npt_pkg.sv
// Shared types and constants of the nested phase time profiler.
// Used by the top level, the overhead divider and the checker; depends on nothing.
`default_nettype none

package npt_pkg;

    // Field widths.
    localparam int PH_W   = 4;
    localparam int TS_W   = 32;
    localparam int CNT_W  = 32;
    localparam int NS_W   = 16;
    localparam int OVH_W  = 39;
    localparam int PRD_W  = CNT_W + NS_W;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 1;

    // Overhead rounding: (reads * ns + ROUND_ADD) / DIVISOR.
    localparam int DIVIDEND_W = PRD_W + 1;
    localparam int DIVISOR    = 1000;
    localparam int ROUND_ADD  = 500;

    // The divider takes the dividend apart in 16-bit digits. Each partial
    // dividend is a remainder below DIVISOR followed by one digit, so it stays
    // below 2^26, where a multiply by ceil(2^36 / 1000) and a shift is exact.
    localparam int DIV_STEPS   = 3;
    localparam int DIV_DIGIT_W = 16;
    localparam int DIV_REM_W   = 10;
    localparam int DIV_V_W     = DIV_REM_W + DIV_DIGIT_W;
    localparam int DIV_RECIP_W = 27;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 27'd68719477;
    localparam int DIV_SHIFT   = 36;
    localparam int DIV_PROD_W  = DIV_V_W + DIV_RECIP_W;
    localparam int DIV_LAT     = 2 * DIV_STEPS + 1;

    // Request register, state update, snapshot, then the divider.
    localparam int LATENCY = DIV_LAT + 2;

    typedef enum logic [1:0] {
        OP_ENTER = 2'd0,
        OP_LEAVE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLOCK_ENABLED = 1'd0,
        CFG_NS_PER_READ   = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] reads;
        logic [CNT_W-1:0] faults;
        logic             reporting;
    } t_snap;

endpackage

`default_nettype wire

>>> hdl/npt_div1000.sv
// Pipelined divide by 1000 for the overhead figure, one 16-bit digit per step.
// Uses constants from npt_pkg.
`default_nettype none

module npt_div1000 (
    input  logic                              i_clk,
    input  logic [npt_pkg::DIVIDEND_W-1:0]    i_dividend,
    output logic [npt_pkg::OVH_W-1:0]         o_quotient
);

    localparam int STEPS = npt_pkg::DIV_STEPS;
    localparam int DIG_W = npt_pkg::DIV_DIGIT_W;
    localparam int V_W   = npt_pkg::DIV_V_W;
    localparam int R_W   = npt_pkg::DIV_REM_W;
    localparam int P_W   = npt_pkg::DIV_PROD_W;
    localparam int LO_W  = (STEPS - 1) * DIG_W;
    localparam int Q_W   = STEPS * DIG_W;

    // Stage A of each step holds the partial dividend, stage B its product.
    logic [V_W-1:0]   r_av  [STEPS];
    logic [LO_W-1:0]  r_alo [STEPS];
    logic [Q_W-1:0]   r_aq  [STEPS];
    logic [V_W-1:0]   n_av  [STEPS];
    logic [LO_W-1:0]  n_alo [STEPS];
    logic [Q_W-1:0]   n_aq  [STEPS];
    logic [P_W-1:0]   r_bp  [STEPS];
    logic [V_W-1:0]   r_bv  [STEPS];
    logic [LO_W-1:0]  r_blo [STEPS];
    logic [Q_W-1:0]   r_bq  [STEPS];
    logic [DIG_W-1:0] w_digit [STEPS];
    logic [R_W-1:0]   w_rem   [STEPS];
    logic [Q_W-1:0]   w_qfull;
    logic [npt_pkg::OVH_W-1:0] r_quot;

    always_comb begin
        for (int s = 0; s < STEPS; s++) begin
            w_digit[s] = r_bp[s][npt_pkg::DIV_SHIFT +: DIG_W];
            w_rem[s]   = R_W'(r_bv[s] - V_W'(w_digit[s]) * V_W'(npt_pkg::DIVISOR));
        end

        n_av[0]  = V_W'(i_dividend[npt_pkg::DIVIDEND_W-1:LO_W]);
        n_alo[0] = i_dividend[LO_W-1:0];
        n_aq[0]  = '0;
        for (int s = 1; s < STEPS; s++) begin
            n_av[s]  = {w_rem[s-1], r_blo[s-1][LO_W-1 -: DIG_W]};
            n_alo[s] = r_blo[s-1] << DIG_W;
            n_aq[s]  = {r_bq[s-1][Q_W-DIG_W-1:0], w_digit[s-1]};
        end

        w_qfull = {r_bq[STEPS-1][Q_W-DIG_W-1:0], w_digit[STEPS-1]};
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < STEPS; s++) begin
            r_av[s]  <= n_av[s];
            r_alo[s] <= n_alo[s];
            r_aq[s]  <= n_aq[s];
            r_bp[s]  <= P_W'(r_av[s]) * P_W'(npt_pkg::DIV_RECIP);
            r_bv[s]  <= r_av[s];
            r_blo[s] <= r_alo[s];
            r_bq[s]  <= r_aq[s];
        end
        r_quot <= w_qfull[npt_pkg::OVH_W-1:0];
    end

    assign o_quotient = r_quot;

endmodule

`default_nettype wire

>>> hdl/nested_phase_time_profiler_top.sv
// Throughput: one request per cycle while busy is low; the stack and all counters
// update together from the request register, and the 7-stage divide by 1000 of the
// overhead sets the latency.
// Results come on a fixed schedule; the receiver cannot stall them.
// Reset (synchronous, active low) clears counters, stack depth, configuration and
// valid flags; busy is high only while reset is applied.
`default_nettype none

module nested_phase_time_profiler_top #(
    parameter int PHASE_COUNT = 8,
    parameter int STACK_DEPTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_op,
    input  logic [npt_pkg::PH_W-1:0]        i_phase,
    input  logic [npt_pkg::TS_W-1:0]        i_now_us,
    input  logic                            i_cfg_we,
    input  logic [npt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [npt_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                            o_result_valid,
    output logic [npt_pkg::CNT_W-1:0]       o_phase_total_us,
    output logic [npt_pkg::CNT_W-1:0]       o_clock_reads,
    output logic [npt_pkg::CNT_W-1:0]       o_fault_count,
    output logic                            o_reporting,
    output logic [npt_pkg::OVH_W-1:0]       o_overhead_us
);

    localparam int PH_W   = npt_pkg::PH_W;
    localparam int CNT_W  = npt_pkg::CNT_W;
    localparam int DEP_W  = $clog2(STACK_DEPTH + 1);
    localparam int SA_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SMEM_N = 1 << SA_W;
    localparam int DL_N   = npt_pkg::DIV_LAT;
    localparam logic [PH_W:0] PH_LIM = (PH_W + 1)'(PHASE_COUNT);

    // Configuration.
    logic                     r_clk_en;
    logic [npt_pkg::NS_W-1:0] r_ns_per_read;

    // Request register.
    logic                    r_in_valid;
    npt_pkg::t_op            r_in_op;
    logic [PH_W-1:0]         r_in_ph;
    logic [npt_pkg::TS_W-1:0] r_in_now;

    // Profiler state. The top of the stack lives in r_top; the entries below it
    // sit in r_stack, and r_below holds the entry just under the top.
    logic [CNT_W-1:0]  r_total [PHASE_COUNT];
    logic [PH_W-1:0]   r_stack [SMEM_N];
    logic [PH_W-1:0]   r_top;
    logic [PH_W-1:0]   r_below;
    logic [DEP_W-1:0]  r_depth;
    logic [CNT_W-1:0]  r_dropped;
    logic [npt_pkg::TS_W-1:0] r_mark;
    logic [CNT_W-1:0]  r_reads;
    logic [CNT_W-1:0]  r_faults;
    logic              r_measured;

    logic [PH_W-1:0]   n_top;
    logic [DEP_W-1:0]  n_depth;
    logic [CNT_W-1:0]  n_dropped;
    logic [npt_pkg::TS_W-1:0] n_mark;
    logic [CNT_W-1:0]  n_reads;
    logic [CNT_W-1:0]  n_faults;
    logic              n_measured;
    logic              n_clear;
    logic              w_charge;
    logic              w_push;
    logic              w_active;
    logic              w_full;
    logic              w_top_match;
    logic [npt_pkg::TS_W-1:0] w_elapsed;
    logic [SA_W-1:0]   w_wr_addr;
    logic [SA_W-1:0]   w_rd_addr;

    // Snapshot stage.
    logic              r_s_valid;
    logic [PH_W-1:0]   r_s_ph;
    logic [CNT_W-1:0]  w_total;
    logic              r_snap_valid;
    npt_pkg::t_snap    r_snap;
    logic [npt_pkg::PRD_W-1:0] r_prd;

    // Snapshot fields wait here while the divider works.
    logic              r_dl_valid [DL_N];
    npt_pkg::t_snap    r_dl_snap  [DL_N];
    logic [npt_pkg::DIVIDEND_W-1:0] w_dividend;
    logic [npt_pkg::OVH_W-1:0]      w_overhead;

    assign busy = ~i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_en      <= 1'b0;
            r_ns_per_read <= '0;
        end else if (i_cfg_we) begin
            unique case (npt_pkg::t_cfg_idx'(i_cfg_idx))
                npt_pkg::CFG_CLOCK_ENABLED: r_clk_en      <= i_cfg_wdata[0];
                npt_pkg::CFG_NS_PER_READ:   r_ns_per_read <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
        end
        r_in_op  <= npt_pkg::t_op'(i_op);
        r_in_ph  <= i_phase;
        r_in_now <= i_now_us;
    end

    assign w_active    = r_clk_en && ({1'b0, r_in_ph} < PH_LIM);
    assign w_full      = (r_depth == DEP_W'(STACK_DEPTH));
    assign w_top_match = (r_depth != '0) && (r_top == r_in_ph);
    assign w_elapsed   = r_in_now - r_mark;

    always_comb begin
        n_top      = r_top;
        n_depth    = r_depth;
        n_dropped  = r_dropped;
        n_mark     = r_mark;
        n_reads    = r_reads;
        n_faults   = r_faults;
        n_measured = r_measured;
        n_clear    = 1'b0;
        w_charge   = 1'b0;
        w_push     = 1'b0;
        if (r_in_valid) begin
            unique case (r_in_op)
                npt_pkg::OP_ENTER: begin
                    if (w_active) begin
                        if (w_full) begin
                            n_dropped = r_dropped + 1'b1;
                            n_faults  = r_faults + 1'b1;
                        end else begin
                            n_reads    = r_reads + 1'b1;
                            n_measured = 1'b1;
                            // The open phase is charged and moves below the new top.
                            w_charge   = (r_depth != '0);
                            w_push     = (r_depth != '0);
                            n_top      = r_in_ph;
                            n_depth    = r_depth + 1'b1;
                            n_mark     = r_in_now;
                        end
                    end
                end
                npt_pkg::OP_LEAVE: begin
                    if (w_active) begin
                        if (r_dropped != '0) begin
                            n_dropped = r_dropped - 1'b1;
                        end else if (!w_top_match) begin
                            n_faults = r_faults + 1'b1;
                        end else begin
                            n_reads  = r_reads + 1'b1;
                            n_depth  = r_depth - 1'b1;
                            w_charge = 1'b1;
                            n_top    = r_below;
                            n_mark   = r_in_now;
                        end
                    end
                end
                npt_pkg::OP_CLEAR: begin
                    n_clear    = 1'b1;
                    n_depth    = '0;
                    n_dropped  = '0;
                    n_mark     = '0;
                    n_reads    = '0;
                    n_faults   = '0;
                    n_measured = 1'b0;
                end
                npt_pkg::OP_QUERY: begin
                end
            endcase
        end
    end

    // The entry under the new top is read ahead and registered with the new top, so a
    // pop can use it at once. A push writes that very entry, which is forwarded.
    assign w_wr_addr = SA_W'(r_depth - DEP_W'(1));
    assign w_rd_addr = SA_W'({1'b0, n_depth} - (DEP_W + 1)'(2));

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[w_wr_addr] <= r_top;
        end
        if (w_push && (w_wr_addr == w_rd_addr)) begin
            r_below <= r_top;
        end else begin
            r_below <= r_stack[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= '0;
            r_dropped  <= '0;
            r_mark     <= '0;
            r_reads    <= '0;
            r_faults   <= '0;
            r_measured <= 1'b0;
        end else begin
            r_depth    <= n_depth;
            r_dropped  <= n_dropped;
            r_mark     <= n_mark;
            r_reads    <= n_reads;
            r_faults   <= n_faults;
            r_measured <= n_measured;
        end
        r_top <= n_top;
    end

    // One accumulator per phase; the charged phase is always the old top.
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (!i_rst_n || n_clear) begin
                r_total[p] <= '0;
            end else if (w_charge && (r_top == PH_W'(p))) begin
                r_total[p] <= r_total[p] + w_elapsed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else begin
            r_s_valid <= r_in_valid;
        end
        r_s_ph <= r_in_ph;
    end

    always_comb begin
        w_total = '0;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (r_s_ph == PH_W'(p)) begin
                w_total = r_total[p];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else begin
            r_snap_valid <= r_s_valid;
        end
        r_snap.total     <= w_total;
        r_snap.reads     <= r_reads;
        r_snap.faults    <= r_faults;
        r_snap.reporting <= r_clk_en & r_measured;
        r_prd <= npt_pkg::PRD_W'(r_reads) * npt_pkg::PRD_W'(r_ns_per_read);
    end

    assign w_dividend = npt_pkg::DIVIDEND_W'(r_prd)
                      + npt_pkg::DIVIDEND_W'(npt_pkg::ROUND_ADD);

    npt_div1000 u_div (
        .i_clk      (i_clk),
        .i_dividend (w_dividend),
        .o_quotient (w_overhead)
    );

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DL_N; k++) begin
            if (!i_rst_n) begin
                r_dl_valid[k] <= 1'b0;
            end else if (k == 0) begin
                r_dl_valid[k] <= r_snap_valid;
            end else begin
                r_dl_valid[k] <= r_dl_valid[k-1];
            end
            if (k == 0) begin
                r_dl_snap[k] <= r_snap;
            end else begin
                r_dl_snap[k] <= r_dl_snap[k-1];
            end
        end
    end

    assign o_result_valid   = r_dl_valid[DL_N-1];
    assign o_phase_total_us = r_dl_snap[DL_N-1].total;
    assign o_clock_reads    = r_dl_snap[DL_N-1].reads;
    assign o_fault_count    = r_dl_snap[DL_N-1].faults;
    assign o_reporting      = r_dl_snap[DL_N-1].reporting;
    assign o_overhead_us    = w_overhead;

endmodule

`default_nettype wire

>>> hdl/npt_checker.sv
// Port-level checks of the nested phase time profiler, bound to the top level.
// Uses npt_pkg for the latency and the request codes.
`default_nettype none

module npt_checker #(
    parameter int PHASE_COUNT = 8
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [1:0]                    i_op,
    input wire logic [npt_pkg::PH_W-1:0]      i_phase,
    input wire logic                          o_result_valid,
    input wire logic [npt_pkg::CNT_W-1:0]     o_phase_total_us,
    input wire logic [npt_pkg::CNT_W-1:0]     o_clock_reads,
    input wire logic [npt_pkg::CNT_W-1:0]     o_fault_count,
    input wire logic                          o_reporting,
    input wire logic [npt_pkg::OVH_W-1:0]     o_overhead_us
);

    // GAP spans from the request edge to the edge at which the assertion samples the strobe.
    localparam int GAP = npt_pkg::LATENCY + 1;

    // Every request yields exactly one result strobe, and no strobe comes without a request.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (o_result_valid == $past(start && !busy, GAP)))
        else $error("result strobe does not follow its request");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && ($past(i_op, GAP) == npt_pkg::OP_CLEAR)) |->
        (o_phase_total_us == '0 && o_clock_reads == '0 && o_fault_count == '0 &&
         o_overhead_us == '0 && !o_reporting))
        else $error("snapshot after a clear is not zero");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid &&
         ({1'b0, $past(i_phase, GAP)} >= (npt_pkg::PH_W + 1)'(PHASE_COUNT)))
        |-> (o_phase_total_us == '0))
        else $error("total of an unknown phase is not zero");

    // Back-to-back results come from back-to-back requests: faults grow by one at most.
    a_fault_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(o_result_valid) &&
         ($past(i_op, GAP) != npt_pkg::OP_CLEAR)) |->
        (o_fault_count == $past(o_fault_count) ||
         o_fault_count == $past(o_fault_count) + 1'b1))
        else $error("fault count jumped between results");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result strobe after reset");

endmodule

bind nested_phase_time_profiler_top npt_checker #(
    .PHASE_COUNT (PHASE_COUNT)
) u_npt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_op             (i_op),
    .i_phase          (i_phase),
    .o_result_valid   (o_result_valid),
    .o_phase_total_us (o_phase_total_us),
    .o_clock_reads    (o_clock_reads),
    .o_fault_count    (o_fault_count),
    .o_reporting      (o_reporting),
    .o_overhead_us    (o_overhead_us)
);

`default_nettype wire
